// ===== hw/rtl/ipg_pkg.sv =====
// Shared types and constants for the image pyramid gradient block.
`timescale 1ns / 1ps

package ipg_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COLOUR = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_LEVELS = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [10:0] RST_HEIGHT = 11'd480;
	localparam logic [2:0]  RST_LEVELS = 3'd4;

	// Last read beat index of a neighborhood fetch and last square root step index.
	localparam logic [2:0] RD_BEATS   = 3'd4;
	localparam logic [4:0] SQRT_LAST  = 5'd24;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_AVG_RD,
		ST_AVG_SUM,
		ST_WRITE,
		ST_GRAD_RD,
		ST_GRAD_CALC,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQRT_INIT,
		ST_SQRT_STEP,
		ST_PUSH,
		ST_NEXT,
		ST_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       lvl_load;
		logic       avg_rd;
		logic       grad_rd;
		logic [2:0] rd_k;
		logic       avg_sum;
		logic       wr;
		logic       grad_calc;
		logic       sq_x;
		logic       sq_y;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       push;
		logic       flush;
		logic       lvl_inc;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic lvl_ok;
		logic lvl_zero;
		logic need_grad;
		logic pend_valid;
		logic out_free;
	} sts_t;

	// One result pixel.
	typedef struct packed {
		logic [24:0]        magnitude;
		logic signed [24:0] grad_y;
		logic signed [24:0] grad_x;
		logic [23:0]        intensity;
		logic [9:0]         row;
		logic [9:0]         column;
		logic [1:0]         level;
	} res_t;

endpackage

// ===== hw/rtl/image_pyramid_gradient_top.sv =====
// Top level of the image pyramid gradient block: ports, configuration and wiring.
`timescale 1ns / 1ps

// Image pyramid with central-difference gradient.
// Input channel s_axis: one base-level pixel per beat in raster order, gray or
// blue/green/red as colour_mode selects. Output channel m_axis: result pixels of
// interior rows, in level order; tlast marks the final result caused by a pixel.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (colour mode,
// width, height, level count) at the clock edge; write only while the block is idle.
// One pixel at a time, taken only in the idle state. At each level it reaches,
// the pixel (above the base level the 2x2 average) goes to the row store, then
// a gradient result needs neighbor reads, squares and a serial square root;
// the square root and the single read port of the row store set the pace.
// A result is held one level back so that its last flag is known; it reaches
// the output register when the next result or the end of the pixel is found.
// While the receiver stalls, the output register holds its beat and the block
// keeps working until it has a second result to hand over, then waits.
// Reset (arst_n low) clears the control state, the frame position and the
// configuration to gray mode, 640 x 480, four levels. The row store is not
// cleared: each row is written before it is read within a frame.

module image_pyramid_gradient_top
	import ipg_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_LEVELS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,  // blue_or_gray[7:0], green[15:8], red[23:16]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// level[1:0], column[11:2], row[21:12], intensity[45:22], grad_x[70:46],
	// grad_y[95:71], magnitude[120:96], zero fill[127:121]
	output logic [127:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [10:0]  cfg_data
);

	logic        colour_q;
	logic [10:0] width_q, height_q;
	logic [2:0]  levels_q;
	cmd_t        cmd;
	sts_t        sts;
	res_t        res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= 1'b0;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			levels_q <= RST_LEVELS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_COLOUR: colour_q <= cfg_data[0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_LEVELS: levels_q <= cfg_data[2:0];
				default:    colour_q <= colour_q;
			endcase
		end
	end

	ipg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ipg_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_data      (s_axis_tdata),
		.colour_mode  (colour_q),
		.frame_width  (width_q),
		.frame_height (height_q),
		.levels_used  (levels_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_res      (res),
		.out_last     (m_axis_tlast)
	);

	// Pack the result fields, the level field in the lowest bits, zero fill on top.
	assign m_axis_tdata = {7'd0, res};

endmodule

// ===== hw/rtl/ipg_ctrl.sv =====
// Controller state machine that sequences the per-level work of one pixel.
`timescale 1ns / 1ps

module ipg_ctrl
	import ipg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [2:0] k_q, k_d;
	logic [4:0] cnt_q, cnt_d;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.rd_k = k_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				if (!sts.lvl_ok) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.lvl_load = 1'b1;
					state_d      = sts.lvl_zero ? ST_WRITE : ST_AVG_RD;
				end
			end
			ST_AVG_RD: begin
				cmd.avg_rd = 1'b1;
				if (k_q == RD_BEATS) begin
					k_d     = '0;
					state_d = ST_AVG_SUM;
				end else begin
					k_d = k_q + 3'd1;
				end
			end
			ST_AVG_SUM: begin
				cmd.avg_sum = 1'b1;
				state_d     = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = sts.need_grad ? ST_GRAD_RD : ST_NEXT;
			end
			ST_GRAD_RD: begin
				cmd.grad_rd = 1'b1;
				if (k_q == RD_BEATS) begin
					k_d     = '0;
					state_d = ST_GRAD_CALC;
				end else begin
					k_d = k_q + 3'd1;
				end
			end
			ST_GRAD_CALC: begin
				cmd.grad_calc = 1'b1;
				state_d       = ST_SQ_X;
			end
			ST_SQ_X: begin
				cmd.sq_x = 1'b1;
				state_d  = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				cmd.sq_y = 1'b1;
				state_d  = ST_SQRT_INIT;
			end
			ST_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				cnt_d         = '0;
				state_d       = ST_SQRT_STEP;
			end
			ST_SQRT_STEP: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == SQRT_LAST) begin
					state_d = ST_PUSH;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_PUSH: begin
				if (!sts.pend_valid || sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.lvl_inc = 1'b1;
				state_d     = ST_LEVEL;
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/ipg_dp.sv =====
// Datapath: row store memory, box average, gradient, square root and output stage.
`timescale 1ns / 1ps

module ipg_dp
	import ipg_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_LEVELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [23:0] in_data,
	input  logic        colour_mode,
	input  logic [10:0] frame_width,
	input  logic [10:0] frame_height,
	input  logic [2:0]  levels_used,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_res,
	output logic        out_last
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int EWW   = $clog2(MAX_WIDTH + 1);
	localparam int EHW   = $clog2(MAX_HEIGHT + 1);
	localparam int LW    = $clog2(MAX_LEVELS + 1);
	localparam int LIW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int RIW   = $clog2(MAX_LEVELS * 3);
	localparam int AW    = RIW + XW;
	localparam int DEPTH = 1 << AW;

	function automatic logic [1:0] mod3(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

	function automatic logic [1:0] inc3(input logic [1:0] a);
		return (a == 2'd2) ? 2'd0 : a + 2'd1;
	endfunction

	function automatic logic [1:0] dec3(input logic [1:0] a);
		return (a == 2'd0) ? 2'd2 : a - 2'd1;
	endfunction

	function automatic logic [RIW-1:0] row_sel(input logic [LIW-1:0] lev, input logic [1:0] slot);
		return RIW'(lev) * RIW'(3) + RIW'(slot);
	endfunction

	// Clamped frame geometry.
	logic [15:0]    fw16, fh16;
	logic [EWW-1:0] ew;
	logic [EHW-1:0] eh;
	logic [LW-1:0]  nl;

	always_comb begin
		fw16 = 16'(frame_width);
		fh16 = 16'(frame_height);
		if (fw16 < 16'd2) ew = EWW'(2);
		else if (fw16 > 16'(MAX_WIDTH)) ew = EWW'(MAX_WIDTH);
		else ew = EWW'(fw16);
		if (fh16 < 16'd3) eh = EHW'(3);
		else if (fh16 > 16'(MAX_HEIGHT)) eh = EHW'(MAX_HEIGHT);
		else eh = EHW'(fh16);
		if (levels_used == 3'd0) nl = LW'(1);
		else if (4'(levels_used) > 4'(MAX_LEVELS)) nl = LW'(MAX_LEVELS);
		else nl = LW'(levels_used);
	end

	// Base position and the position of the pixel being worked on.
	logic [XW-1:0]  pos_c_q, cur_c_q, c_in;
	logic [YW-1:0]  pos_r_q, cur_r_q, r_in;
	logic [EWW-1:0] c_inc;
	logic [EHW-1:0] r_inc;
	logic [15:0]    gray;

	always_comb begin
		c_in  = (EWW'(pos_c_q) >= ew) ? '0 : pos_c_q;
		r_in  = (EHW'(pos_r_q) >= eh) ? '0 : pos_r_q;
		c_inc = EWW'(c_in) + EWW'(1);
		r_inc = EHW'(r_in) + EHW'(1);
		gray  = 16'(in_data[23:16]) * 16'd77 + 16'(in_data[15:8]) * 16'd150
		      + 16'(in_data[7:0]) * 16'd29;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_c_q <= '0;
			pos_r_q <= '0;
		end else if (cmd.accept) begin
			if (c_inc >= ew) begin
				pos_c_q <= '0;
				pos_r_q <= (r_inc >= eh) ? '0 : YW'(r_inc);
			end else begin
				pos_c_q <= XW'(c_inc);
				pos_r_q <= r_in;
			end
		end
	end

	// Level counter and level geometry.
	logic [LW-1:0]  lvl_q;
	logic [EWW-1:0] wl_c, wl_q;
	logic [EHW-1:0] hl_c;
	logic [XW-1:0]  x_c, x_q, cmask;
	logic [YW-1:0]  y_c, y_q, rmask;
	logic [1:0]     ym3_q;
	logic           lvl_ok;

	always_comb begin
		wl_c   = ew >> lvl_q;
		hl_c   = eh >> lvl_q;
		x_c    = cur_c_q >> lvl_q;
		y_c    = cur_r_q >> lvl_q;
		cmask  = ~({XW{1'b1}} << lvl_q);
		rmask  = ~({YW{1'b1}} << lvl_q);
		lvl_ok = (lvl_q < nl) && (wl_c != '0) && (hl_c != '0)
		      && ((cur_c_q & cmask) == cmask) && ((cur_r_q & rmask) == rmask)
		      && (EWW'(x_c) < wl_c) && (EHW'(y_c) < hl_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.accept) begin
			lvl_q <= '0;
		end else if (cmd.lvl_inc) begin
			lvl_q <= lvl_q + LW'(1);
		end
	end

	logic [23:0] v_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_c_q <= c_in;
			cur_r_q <= r_in;
		end
		if (cmd.lvl_load) begin
			x_q   <= x_c;
			y_q   <= y_c;
			wl_q  <= wl_c;
			ym3_q <= mod3(16'(y_c));
		end
	end

	// Row store: one write port, one registered read port.
	logic [23:0]   mem [DEPTH];
	logic [AW-1:0] raddr, waddr;
	logic [23:0]   rdq;
	logic [LIW-1:0] lev_cur, lev_prev;
	logic [1:0]    sc, su;
	logic [XW-1:0] x2;

	always_comb begin
		lev_cur  = LIW'(lvl_q);
		lev_prev = LIW'(lvl_q - LW'(1));
		sc       = dec3(ym3_q);
		su       = inc3(ym3_q);
		x2       = XW'({x_q, 1'b0});
		waddr    = {row_sel(lev_cur, ym3_q), x_q};
		raddr    = '0;
		if (cmd.avg_rd) begin
			// Rows 2y and 2y+1 of the level below.
			case (cmd.rd_k)
				3'd0: raddr = {row_sel(lev_prev, (ym3_q == 2'd0) ? 2'd0 :
					(ym3_q == 2'd1) ? 2'd2 : 2'd1), x2};
				3'd1: raddr = {row_sel(lev_prev, (ym3_q == 2'd0) ? 2'd0 :
					(ym3_q == 2'd1) ? 2'd2 : 2'd1), x2 | XW'(1)};
				3'd2: raddr = {row_sel(lev_prev, (ym3_q == 2'd0) ? 2'd1 :
					(ym3_q == 2'd1) ? 2'd0 : 2'd2), x2};
				3'd3: raddr = {row_sel(lev_prev, (ym3_q == 2'd0) ? 2'd1 :
					(ym3_q == 2'd1) ? 2'd0 : 2'd2), x2 | XW'(1)};
				default: raddr = '0;
			endcase
		end else if (cmd.grad_rd) begin
			// Center, up, right and left neighbors of the row above.
			case (cmd.rd_k)
				3'd0: raddr = {row_sel(lev_cur, sc), x_q};
				3'd1: raddr = {row_sel(lev_cur, su), x_q};
				3'd2: begin
					if (EWW'(x_q) + EWW'(1) < wl_q) raddr = {row_sel(lev_cur, sc), x_q + XW'(1)};
					else raddr = {row_sel(lev_cur, ym3_q), XW'(0)};
				end
				3'd3: begin
					if (x_q != '0) raddr = {row_sel(lev_cur, sc), x_q - XW'(1)};
					else raddr = {row_sel(lev_cur, su), XW'(wl_q - EWW'(1))};
				end
				default: raddr = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr] <= v_q;
		end
		rdq <= mem[raddr];
	end

	// Fetched words, captured from the registered read port on the beat after their address.
	logic [23:0] slot_q [4];
	logic [2:0]  cap_k;

	assign cap_k = cmd.rd_k - 3'd1;

	always_ff @(posedge clk) begin
		if ((cmd.avg_rd || cmd.grad_rd) && cmd.rd_k != 3'd0) begin
			slot_q[cap_k[1:0]] <= rdq;
		end
	end

	// Box average, differences, squares and the square root.
	logic [25:0]        sum4;
	logic [23:0]        ctr_q, ax_q, ay_q;
	logic signed [24:0] gx_q, gy_q;
	logic [47:0]        pa_q, pb_q;
	logic [49:0]        rad_q;
	logic [27:0]        rem_q, rem_cand, trial;
	logic [24:0]        root_q;

	always_comb begin
		sum4     = 26'(slot_q[0]) + 26'(slot_q[1]) + 26'(slot_q[2]) + 26'(slot_q[3]);
		rem_cand = {rem_q[25:0], rad_q[49:48]};
		trial    = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk) begin
		// The working intensity: the new base pixel, then each level's average.
		if (cmd.accept) begin
			v_q <= colour_mode ? {gray, 8'd0} : {in_data[7:0], 16'd0};
		end else if (cmd.avg_sum) begin
			v_q <= sum4[25:2];
		end
		if (cmd.grad_calc) begin
			ctr_q <= slot_q[0];
			gx_q  <= $signed({1'b0, slot_q[2]}) - $signed({1'b0, slot_q[3]});
			gy_q  <= $signed({1'b0, v_q}) - $signed({1'b0, slot_q[1]});
			ax_q  <= (slot_q[2] >= slot_q[3]) ? slot_q[2] - slot_q[3] : slot_q[3] - slot_q[2];
			ay_q  <= (v_q >= slot_q[1]) ? v_q - slot_q[1] : slot_q[1] - v_q;
		end
		if (cmd.sq_x) begin
			pa_q <= 48'(ax_q) * 48'(ax_q);
		end
		if (cmd.sq_y) begin
			pb_q <= 48'(ay_q) * 48'(ay_q);
		end
		if (cmd.sqrt_init) begin
			rad_q  <= 50'(pa_q) + 50'(pb_q);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[47:0], 2'b00};
			if (rem_cand >= trial) begin
				rem_q  <= rem_cand - trial;
				root_q <= {root_q[23:0], 1'b1};
			end else begin
				rem_q  <= rem_cand;
				root_q <= {root_q[23:0], 1'b0};
			end
		end
	end

	// One result held back so the final one of a pixel can be marked.
	res_t res_new, pend_q;
	logic pend_v_q, out_v_q;

	always_comb begin
		res_new.level     = 2'(lvl_q);
		res_new.column    = 10'(x_q);
		res_new.row       = 10'(y_q - YW'(1));
		res_new.intensity = ctr_q;
		res_new.grad_x    = gx_q;
		res_new.grad_y    = gy_q;
		res_new.magnitude = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.push) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
			if ((cmd.push || cmd.flush) && pend_v_q) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_q <= res_new;
		end
		if ((cmd.push || cmd.flush) && pend_v_q) begin
			out_res  <= pend_q;
			out_last <= cmd.flush;
		end
	end

	assign out_valid      = out_v_q;
	assign sts.lvl_ok     = lvl_ok;
	assign sts.lvl_zero   = (lvl_q == '0);
	assign sts.need_grad  = (y_q >= YW'(2));
	assign sts.pend_valid = pend_v_q;
	assign sts.out_free   = !out_v_q || out_ready;

endmodule
